>>> rtl/sobel_pkg.sv
// Shared constants, types and register codes for the Sobel edge threshold block.
`timescale 1ns / 1ps

package sobel_pkg;

	localparam int MAX_WIDTH = 2048;
	localparam int CNT_W     = $clog2(MAX_WIDTH);
	localparam int IW_W      = 12;
	localparam int IH_W      = 16;
	localparam int THR_W     = 21;
	localparam int PIX_W     = 8;
	localparam int CMP_W     = ((CNT_W > IW_W) ? CNT_W : IW_W) + 1;
	localparam int ROW_W     = IH_W + 1;
	localparam int GRAD_W    = 11;
	localparam int MAG_W     = 22;
	localparam int PADDR_W   = 4;
	localparam int PDATA_W   = 32;

	localparam logic [THR_W-1:0] THR_RESET    = THR_W'(4000);
	localparam logic [IW_W-1:0]  WIDTH_RESET  = IW_W'(640);
	localparam logic [IH_W-1:0]  HEIGHT_RESET = IH_W'(480);
	localparam logic [PIX_W-1:0] EDGE_ON      = PIX_W'(255);
	localparam logic [PIX_W-1:0] EDGE_OFF     = '0;

	typedef enum logic [1:0] {
		CFG_THRESHOLD = 2'd0,
		CFG_WIDTH     = 2'd1,
		CFG_HEIGHT    = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [THR_W-1:0] threshold;
		logic [IW_W-1:0]  image_width;
		logic [IH_W-1:0]  image_height;
	} cfg_t;

	typedef struct packed {
		logic [CNT_W-1:0] col;
		logic             emit;
		logic             frame_end;
	} pos_t;

endpackage

>>> rtl/sobel_if.sv
// Valid/ready stream interfaces for the pixel input and the edge result output.
`timescale 1ns / 1ps

interface sobel_pix_if;
	logic                        valid;
	logic                        ready;
	logic [sobel_pkg::PIX_W-1:0] pixel;
	logic                        frame_start;

	modport source (output valid, output pixel, output frame_start, input ready);
	modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

interface sobel_res_if;
	logic                        valid;
	logic                        ready;
	logic [sobel_pkg::PIX_W-1:0] edge_res;
	logic                        frame_end;

	modport source (output valid, output edge_res, output frame_end, input ready);
	modport sink (input valid, input edge_res, input frame_end, output ready);
endinterface

>>> rtl/sobel_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sobel_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/sobel_cfg.sv
// APB register file holding threshold, image width and image height.
`timescale 1ns / 1ps

module sobel_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sobel_pkg::PADDR_W-1:0] paddr,
	input  logic [sobel_pkg::PDATA_W-1:0] pwdata,
	output logic [sobel_pkg::PDATA_W-1:0] prdata,
	output logic                          pready,
	output sobel_pkg::cfg_t               cfg
);

	sobel_pkg::cfg_t      cfg_q;
	sobel_pkg::cfg_idx_t  idx;
	logic                 wr_en;

	assign idx    = sobel_pkg::cfg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold    <= sobel_pkg::THR_RESET;
			cfg_q.image_width  <= sobel_pkg::WIDTH_RESET;
			cfg_q.image_height <= sobel_pkg::HEIGHT_RESET;
		end else if (wr_en) begin
			unique case (idx)
				sobel_pkg::CFG_THRESHOLD: begin
					cfg_q.threshold <= pwdata[sobel_pkg::THR_W-1:0];
				end
				sobel_pkg::CFG_WIDTH: begin
					cfg_q.image_width <= pwdata[sobel_pkg::IW_W-1:0];
				end
				sobel_pkg::CFG_HEIGHT: begin
					cfg_q.image_height <= pwdata[sobel_pkg::IH_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			sobel_pkg::CFG_THRESHOLD: begin
				prdata = sobel_pkg::PDATA_W'(cfg_q.threshold);
			end
			sobel_pkg::CFG_WIDTH: begin
				prdata = sobel_pkg::PDATA_W'(cfg_q.image_width);
			end
			sobel_pkg::CFG_HEIGHT: begin
				prdata = sobel_pkg::PDATA_W'(cfg_q.image_height);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

endmodule

>>> rtl/sobel_pos.sv
// Raster position tracker: column and row counters with wrap and frame restart.
`timescale 1ns / 1ps

module sobel_pos (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  logic            frame_start,
	input  sobel_pkg::cfg_t cfg,
	output sobel_pkg::pos_t pos
);

	logic [sobel_pkg::CNT_W-1:0] col_q, col_a, col_b;
	logic [sobel_pkg::IH_W-1:0]  row_q, row_a, row_c;
	logic [sobel_pkg::ROW_W-1:0] row_b;
	logic [sobel_pkg::CMP_W-1:0] w_eff;
	logic [sobel_pkg::ROW_W-1:0] h_eff;
	logic                        last_col, last_row;

	// Clamp the configured size to what the line buffers and window allow.
	always_comb begin
		if (sobel_pkg::CMP_W'(cfg.image_width) < sobel_pkg::CMP_W'(3)) begin
			w_eff = sobel_pkg::CMP_W'(3);
		end else if (sobel_pkg::CMP_W'(cfg.image_width) > sobel_pkg::CMP_W'(sobel_pkg::MAX_WIDTH))
		begin
			w_eff = sobel_pkg::CMP_W'(sobel_pkg::MAX_WIDTH);
		end else begin
			w_eff = sobel_pkg::CMP_W'(cfg.image_width);
		end
		if (cfg.image_height < sobel_pkg::IH_W'(3)) begin
			h_eff = sobel_pkg::ROW_W'(3);
		end else begin
			h_eff = sobel_pkg::ROW_W'(cfg.image_height);
		end
	end

	always_comb begin
		col_a = frame_start ? '0 : col_q;
		row_a = frame_start ? '0 : row_q;
		if (sobel_pkg::CMP_W'(col_a) >= w_eff) begin
			col_b = '0;
			row_b = sobel_pkg::ROW_W'(row_a) + sobel_pkg::ROW_W'(1);
		end else begin
			col_b = col_a;
			row_b = sobel_pkg::ROW_W'(row_a);
		end
		row_c    = (row_b >= h_eff) ? '0 : row_b[sobel_pkg::IH_W-1:0];
		last_col = (sobel_pkg::CMP_W'(col_b) + sobel_pkg::CMP_W'(1)) >= w_eff;
		last_row = (sobel_pkg::ROW_W'(row_c) + sobel_pkg::ROW_W'(1)) >= h_eff;
	end

	assign pos.col       = col_b;
	assign pos.emit      = (row_c >= sobel_pkg::IH_W'(2)) && (col_b >= sobel_pkg::CNT_W'(2));
	assign pos.frame_end = last_col && last_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_c + sobel_pkg::IH_W'(1);
			end else begin
				col_q <= col_b + sobel_pkg::CNT_W'(1);
				row_q <= row_c;
			end
		end
	end

endmodule

>>> rtl/sobel_win.sv
// 3x3 pixel window and the horizontal and vertical Sobel sums over it.
`timescale 1ns / 1ps

module sobel_win (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                shift,
	input  logic [sobel_pkg::PIX_W-1:0]         top,
	input  logic [sobel_pkg::PIX_W-1:0]         mid,
	input  logic [sobel_pkg::PIX_W-1:0]         px,
	output logic signed [sobel_pkg::GRAD_W-1:0] gx,
	output logic signed [sobel_pkg::GRAD_W-1:0] gy
);

	// Only the two older columns are stored; the newest column is the incoming one.
	logic [sobel_pkg::PIX_W-1:0] win_q [6];
	logic signed [sobel_pkg::GRAD_W-1:0] tl, tm, tr, ml, mr, bl, bm, br;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (shift) begin
			win_q[0] <= win_q[1];
			win_q[1] <= top;
			win_q[2] <= win_q[3];
			win_q[3] <= mid;
			win_q[4] <= win_q[5];
			win_q[5] <= px;
		end
	end

	// After the shift the left column is the oldest stored one and the middle
	// column is the newer stored one; the center pixel does not enter the sums.
	assign tl = $signed(sobel_pkg::GRAD_W'(win_q[0]));
	assign tm = $signed(sobel_pkg::GRAD_W'(win_q[1]));
	assign tr = $signed(sobel_pkg::GRAD_W'(top));
	assign ml = $signed(sobel_pkg::GRAD_W'(win_q[2]));
	assign mr = $signed(sobel_pkg::GRAD_W'(mid));
	assign bl = $signed(sobel_pkg::GRAD_W'(win_q[4]));
	assign bm = $signed(sobel_pkg::GRAD_W'(win_q[5]));
	assign br = $signed(sobel_pkg::GRAD_W'(px));

	assign gx = (tr - tl) + ((mr - ml) <<< 1) + (br - bl);
	assign gy = (tl + (tm <<< 1) + tr) - (bl + (bm <<< 1) + br);

endmodule

>>> rtl/sobel_edge_threshold.sv
// Top level: streaming 3x3 Sobel edge detector with a squared-magnitude threshold.
//
//   port group | dir | beat contents             | handshake
//   -----------+-----+---------------------------+----------------------------
//   pix        | in  | pixel, frame_start        | valid/ready
//   res        | out | edge_res, frame_end       | valid/ready
//   apb        | in  | threshold, width, height  | psel/penable/pwrite, pready=1
//
// One pixel beat is taken every cycle when the output side keeps up. A result beat is
// offered once its pixel has passed the stage 1, stage 2 and output registers; border pixels give no result.
// arst_n clears the position counters, window and pipeline valids and loads the
// register reset values; the line buffers are not cleared. While a result waits,
// border pixels keep flowing and up to two more interior pixels enter the pipe
// before pix.ready drops.
`timescale 1ns / 1ps

module sobel_edge_threshold (
	input  logic                          clk,
	input  logic                          arst_n,
	sobel_pix_if.sink                     pix,
	sobel_res_if.source                   res,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sobel_pkg::PADDR_W-1:0] paddr,
	input  logic [sobel_pkg::PDATA_W-1:0] pwdata,
	output logic [sobel_pkg::PDATA_W-1:0] prdata,
	output logic                          pready
);

	sobel_pkg::cfg_t cfg;
	sobel_pkg::pos_t pos;

	logic accept, fire_s1, s2_ready, s3_ready, bypass;

	// Stage 1: line buffer read data arrives alongside the pixel.
	logic                        v_s1;
	logic [sobel_pkg::PIX_W-1:0] px_s1;
	logic [sobel_pkg::CNT_W-1:0] col_s1;
	logic                        emit_s1, fend_s1;
	logic                        byp_s1;
	logic [sobel_pkg::PIX_W-1:0] byp_top_s1, byp_mid_s1;
	logic [sobel_pkg::PIX_W-1:0] top_rd, mid_rd, top_eff, mid_eff;

	// Stage 2: Sobel sums.
	logic                                v_s2;
	logic signed [sobel_pkg::GRAD_W-1:0] gx_s2, gy_s2;
	logic                                fend_s2;
	logic signed [sobel_pkg::GRAD_W-1:0] gx, gy;

	// Stage 3: output register.
	logic                        v_s3;
	logic [sobel_pkg::PIX_W-1:0] edge_s3;
	logic                        fend_s3;
	logic [sobel_pkg::MAG_W-1:0] mag;
	logic signed [2*sobel_pkg::GRAD_W-1:0] sq_x, sq_y;

	sobel_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sobel_pos u_pos (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (accept),
		.frame_start (pix.frame_start),
		.cfg         (cfg),
		.pos         (pos)
	);

	assign s3_ready  = !v_s3 || res.ready;
	assign s2_ready  = !v_s2 || s3_ready;
	assign fire_s1   = v_s1 && (!emit_s1 || s2_ready);
	assign pix.ready = !v_s1 || fire_s1;
	assign accept    = pix.valid && pix.ready;

	// A pixel at the same column as the one being written this cycle would read
	// stale buffer data, so the written values are forwarded instead.
	assign bypass  = accept && fire_s1 && (pos.col == col_s1);
	assign top_eff = byp_s1 ? byp_top_s1 : top_rd;
	assign mid_eff = byp_s1 ? byp_mid_s1 : mid_rd;

	sobel_ram #(
		.WIDTH (sobel_pkg::PIX_W),
		.DEPTH (sobel_pkg::MAX_WIDTH)
	) u_line_above (
		.clk   (clk),
		.we    (fire_s1),
		.waddr (col_s1),
		.wdata (px_s1),
		.re    (accept),
		.raddr (pos.col),
		.rdata (mid_rd)
	);

	sobel_ram #(
		.WIDTH (sobel_pkg::PIX_W),
		.DEPTH (sobel_pkg::MAX_WIDTH)
	) u_line_two_above (
		.clk   (clk),
		.we    (fire_s1),
		.waddr (col_s1),
		.wdata (mid_eff),
		.re    (accept),
		.raddr (pos.col),
		.rdata (top_rd)
	);

	sobel_win u_win (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (fire_s1),
		.top    (top_eff),
		.mid    (mid_eff),
		.px     (px_s1),
		.gx     (gx),
		.gy     (gy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			byp_s1 <= 1'b0;
		end else if (pix.ready) begin
			v_s1   <= pix.valid;
			byp_s1 <= bypass;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1      <= pix.pixel;
			col_s1     <= pos.col;
			emit_s1    <= pos.emit;
			fend_s1    <= pos.frame_end;
			byp_top_s1 <= mid_eff;
			byp_mid_s1 <= px_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s2_ready) begin
			v_s2 <= fire_s1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && emit_s1) begin
			gx_s2   <= gx;
			gy_s2   <= gy;
			fend_s2 <= fend_s1;
		end
	end

	assign sq_x = gx_s2 * gx_s2;
	assign sq_y = gy_s2 * gy_s2;
	assign mag  = sobel_pkg::MAG_W'(sq_x) + sobel_pkg::MAG_W'(sq_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (s3_ready) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_ready && v_s2) begin
			edge_s3 <= (mag > sobel_pkg::MAG_W'(cfg.threshold)) ?
				sobel_pkg::EDGE_ON : sobel_pkg::EDGE_OFF;
			fend_s3 <= fend_s2;
		end
	end

	assign res.valid    = v_s3;
	assign res.edge_res = edge_s3;
	assign res.frame_end = fend_s3;

`ifndef ASSERT_OFF
	a_edge_code: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.edge_res == sobel_pkg::EDGE_ON || res.edge_res == sobel_pkg::EDGE_OFF))
		else $error("edge result is neither full on nor off");

	a_bypass_valid: assert property (@(posedge clk) disable iff (!arst_n)
		byp_s1 |-> v_s1)
		else $error("forwarded buffer data without an item in stage 1");

	a_emit_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && emit_s1) |=> v_s2)
		else $error("interior pixel left stage 1 without reaching stage 2");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !s3_ready) |=> (v_s2 && $stable(gx_s2) && $stable(gy_s2)))
		else $error("stalled Sobel sums changed");
`endif

endmodule
